FILE: rtl/core/mandelbrot_escape_time_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the escape-time unit
// Concurrent checks sampled on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_TIME_UNIT_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_UNIT_MACROS_SVH

// Same-cycle implication
`define MET_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define MET_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/met_pkg.sv
// ----------------------------------------------------------------------------
// met_pkg
// Widths, constants, register indexes and shared types of the escape-time
// unit. Coordinates are signed fixed point with FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
package met_pkg;

	// Geometry and number format (MAX_SIDE must be a power of two)
	localparam int MAX_SIDE   = 4096;
	localparam int FRAC_BITS  = 28;
	localparam int COUNT_BITS = 16;

	// Field widths
	localparam int IDX_W     = 12;
	localparam int CNT_OUT_W = 16;
	localparam int COORD_W   = 32;
	localparam int STEP_W    = 31;
	localparam int DATA_W    = 32;
	localparam int ADDR_W    = 5;
	localparam int REG_IDX_W = 3;

	localparam logic [IDX_W-1:0] SIDE_MASK = IDX_W'(MAX_SIDE - 1);

	// Datapath widths: index * step, offset point, iterate, multiplier operand, product
	localparam int PX_W = IDX_W + STEP_W;
	localparam int CX_W = PX_W + 2;
	localparam int Z_W  = CX_W + 1;
	localparam int M_W  = FRAC_BITS + 3;
	localparam int P_W  = 2 * M_W;

	localparam int QUEUE_DEPTH = 2;

	// Register indexes
	localparam logic [REG_IDX_W-1:0] REG_X_START  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_Y_START  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_X_STEP   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_Y_STEP   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_MAX_ITER = 3'd4;

	// Register reset values: -2.0, -1.25, 3/999, 2.5/999, 1000
	localparam logic signed [COORD_W-1:0] X_START_RST = -32'sd536870912;
	localparam logic signed [COORD_W-1:0] Y_START_RST = -32'sd335544320;
	localparam logic [STEP_W-1:0]         X_STEP_RST  = 31'd806112;
	localparam logic [STEP_W-1:0]         Y_STEP_RST  = 31'd671760;
	localparam logic [CNT_OUT_W-1:0]      MAX_ITER_RST = 16'd1000;

	typedef struct packed {
		logic signed [COORD_W-1:0] x_start;
		logic signed [COORD_W-1:0] y_start;
		logic [STEP_W-1:0]         x_step;
		logic [STEP_W-1:0]         y_step;
		logic [CNT_OUT_W-1:0]      max_iterations;
	} met_cfg_t;

	// One classified pixel waiting for the engine
	typedef struct packed {
		logic signed [CX_W-1:0] cx;
		logic signed [CX_W-1:0] cy;
		logic [IDX_W-1:0]       column;
		logic [IDX_W-1:0]       row;
		logic [CNT_OUT_W-1:0]   limit;
	} met_item_t;

	// One result, column in the lowest bits
	typedef struct packed {
		logic                 stayed_bounded;
		logic [CNT_OUT_W-1:0] iteration_count;
		logic [IDX_W-1:0]     row;
		logic [IDX_W-1:0]     column;
	} met_result_t;

	typedef enum logic [1:0] {
		ENG_IDLE,
		ENG_MUL,
		ENG_ACC,
		ENG_HOLD
	} met_eng_state_t;

endpackage

FILE: rtl/core/met_front.sv
// ----------------------------------------------------------------------------
// met_front
// Accepts pixel requests, maps column and row to the point c and clips the
// iteration limit. Two stages: index times step, then add the start offset.
// ----------------------------------------------------------------------------
module met_front #(
	parameter int COUNT_BITS = met_pkg::COUNT_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  met_pkg::met_cfg_t               cfg,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [met_pkg::IDX_W-1:0]       in_column,
	input  logic [met_pkg::IDX_W-1:0]       in_row,
	output logic                            q_valid,
	input  logic                            q_ready,
	output met_pkg::met_item_t              q_item
);

	localparam int CNT_W = (COUNT_BITS < met_pkg::CNT_OUT_W) ? COUNT_BITS : met_pkg::CNT_OUT_W;
	localparam logic [met_pkg::CNT_OUT_W-1:0] CMAX =
		met_pkg::CNT_OUT_W'((64'd1 << CNT_W) - 64'd1);

	logic                              v_s1;
	logic [met_pkg::IDX_W-1:0]         col_s1;
	logic [met_pkg::IDX_W-1:0]         row_s1;
	logic [met_pkg::PX_W-1:0]          px_s1;
	logic [met_pkg::PX_W-1:0]          py_s1;
	logic [met_pkg::CNT_OUT_W-1:0]     limit_s1;
	logic                              v_s2;
	met_pkg::met_item_t                item_s2;
	logic                              adv_s1;
	logic                              adv_s2;
	logic [met_pkg::IDX_W-1:0]         col_m;
	logic [met_pkg::IDX_W-1:0]         row_m;
	logic [met_pkg::CNT_OUT_W-1:0]     limit_c;

	// Stage advance: a stage moves when the one after it has room
	assign adv_s2   = !v_s2 || q_ready;
	assign adv_s1   = !v_s1 || adv_s2;
	assign in_ready = adv_s1;

	// Wrap indices to the side length, clip the limit to the counter range
	assign col_m   = in_column & met_pkg::SIDE_MASK;
	assign row_m   = in_row & met_pkg::SIDE_MASK;
	assign limit_c = (cfg.max_iterations > CMAX) ? CMAX : cfg.max_iterations;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				v_s1 <= in_valid;
			end
			if (adv_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	// Stage 1: index times step
	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			col_s1   <= in_column;
			row_s1   <= in_row;
			px_s1    <= col_m * cfg.x_step;
			py_s1    <= row_m * cfg.y_step;
			limit_s1 <= limit_c;
		end
	end

	// Stage 2: add the start offset
	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			item_s2.cx     <= met_pkg::CX_W'($signed(cfg.x_start)) + $signed({1'b0, px_s1});
			item_s2.cy     <= met_pkg::CX_W'($signed(cfg.y_start)) + $signed({1'b0, py_s1});
			item_s2.column <= col_s1;
			item_s2.row    <= row_s1;
			item_s2.limit  <= limit_s1;
		end
	end

	assign q_valid = v_s2;
	assign q_item  = item_s2;

endmodule

FILE: rtl/core/met_queue.sv
// ----------------------------------------------------------------------------
// met_queue
// Short register queue between the front stages and the iteration engine.
// ----------------------------------------------------------------------------
`include "mandelbrot_escape_time_unit_macros.svh"

module met_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	output logic               push_ready,
	input  met_pkg::met_item_t push_item,
	output logic               pop_valid,
	input  logic               pop_ready,
	output met_pkg::met_item_t pop_item
);

	localparam int DEPTH = met_pkg::QUEUE_DEPTH;
	localparam int A_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int F_W   = $clog2(DEPTH + 1);

	met_pkg::met_item_t entries_q [DEPTH];
	logic [A_W-1:0]     wr_ptr_q;
	logic [A_W-1:0]     rd_ptr_q;
	logic [F_W-1:0]     fill_q;
	logic               push;
	logic               pop;

	assign push_ready = (fill_q != F_W'(DEPTH));
	assign pop_valid  = (fill_q != '0);
	assign pop_item   = entries_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == A_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == A_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

	`MET_ASSERT_NOW(a_fill_bound, 1'b1, fill_q <= F_W'(DEPTH), "queue fill above depth")
	`MET_ASSERT_NEXT(a_fill_grow, push && !pop, fill_q == $past(fill_q) + 1'b1, "queue fill lost a request")

endmodule

FILE: rtl/core/met_engine.sv
// ----------------------------------------------------------------------------
// met_engine
// Iterates z = z^2 + c for one pixel at a time: a multiply cycle forms the
// two squares and the cross product, an update cycle runs the escape test
// and forms the next z. Finished results wait in an output register.
// ----------------------------------------------------------------------------
`include "mandelbrot_escape_time_unit_macros.svh"

module met_engine #(
	parameter int COUNT_BITS = met_pkg::COUNT_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	output logic                 q_ready,
	input  met_pkg::met_item_t   q_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output met_pkg::met_result_t out_res
);

	localparam int CNT_W = (COUNT_BITS < met_pkg::CNT_OUT_W) ? COUNT_BITS : met_pkg::CNT_OUT_W;
	localparam int Z_W   = met_pkg::Z_W;
	localparam int M_W   = met_pkg::M_W;
	localparam int P_W   = met_pkg::P_W;
	localparam int F     = met_pkg::FRAC_BITS;

	localparam logic signed [Z_W-1:0] TWO_Z  = Z_W'(64'd1 << (F + 1));
	localparam logic signed [Z_W-1:0] NTWO_Z = -TWO_Z;
	localparam logic signed [P_W-1:0] FOUR_P = P_W'(64'd1 << (2 * F + 2));

	met_pkg::met_eng_state_t state_q, state_d;

	logic signed [met_pkg::CX_W-1:0] cx_q;
	logic signed [met_pkg::CX_W-1:0] cy_q;
	logic [met_pkg::IDX_W-1:0]       col_q;
	logic [met_pkg::IDX_W-1:0]       row_q;
	logic [CNT_W-1:0]                limit_q;
	logic [CNT_W-1:0]                count_q;
	logic signed [Z_W-1:0]           x_q;
	logic signed [Z_W-1:0]           y_q;
	logic signed [P_W-1:0]           x2_q;
	logic signed [P_W-1:0]           y2_q;
	logic signed [P_W-1:0]           xy_q;
	logic                            out_valid_q;
	met_pkg::met_result_t            out_res_q;

	logic                  q_pop;
	logic                  mul_en;
	logic                  step_en;
	logic                  out_load;
	logic                  slot_free;
	logic                  stop_mul;
	logic                  escape;
	logic signed [M_W-1:0] xm;
	logic signed [M_W-1:0] ym;
	logic signed [P_W-1:0] mag;
	logic signed [P_W-1:0] diff;
	logic signed [P_W-1:0] dsh;
	logic signed [P_W-1:0] xy2;
	logic signed [P_W-1:0] ysh;
	logic signed [Z_W-1:0] x_next;
	logic signed [Z_W-1:0] y_next;

	assign slot_free = !out_valid_q || out_ready;

	// Multiply cycle: stop at the limit or when a component leaves [-2, 2]
	assign stop_mul = (count_q == limit_q) || (x_q > TWO_Z) || (x_q < NTWO_Z) ||
		(y_q > TWO_Z) || (y_q < NTWO_Z);
	assign xm = x_q[M_W-1:0];
	assign ym = y_q[M_W-1:0];

	// Update cycle: escape test, then floor-scaled new z plus c
	assign mag    = x2_q + y2_q;
	assign escape = (mag > FOUR_P);
	assign diff   = x2_q - y2_q;
	assign dsh    = diff >>> F;
	assign xy2    = xy_q <<< 1;
	assign ysh    = xy2 >>> F;
	assign x_next = $signed(dsh[Z_W-1:0]) + Z_W'(cx_q);
	assign y_next = $signed(ysh[Z_W-1:0]) + Z_W'(cy_q);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= met_pkg::ENG_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and strobes
	always_comb begin
		state_d  = state_q;
		q_pop    = 1'b0;
		mul_en   = 1'b0;
		step_en  = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			met_pkg::ENG_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					state_d = met_pkg::ENG_MUL;
				end
			end
			met_pkg::ENG_MUL: begin
				if (stop_mul) begin
					if (slot_free) begin
						out_load = 1'b1;
						state_d  = met_pkg::ENG_IDLE;
					end else begin
						state_d = met_pkg::ENG_HOLD;
					end
				end else begin
					mul_en  = 1'b1;
					state_d = met_pkg::ENG_ACC;
				end
			end
			met_pkg::ENG_ACC: begin
				if (escape) begin
					if (slot_free) begin
						out_load = 1'b1;
						state_d  = met_pkg::ENG_IDLE;
					end else begin
						state_d = met_pkg::ENG_HOLD;
					end
				end else begin
					step_en = 1'b1;
					state_d = met_pkg::ENG_MUL;
				end
			end
			met_pkg::ENG_HOLD: begin
				if (slot_free) begin
					out_load = 1'b1;
					state_d  = met_pkg::ENG_IDLE;
				end
			end
			default: begin
				state_d = met_pkg::ENG_IDLE;
			end
		endcase
	end

	// Pixel context, iterate and products
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cx_q    <= q_item.cx;
			cy_q    <= q_item.cy;
			col_q   <= q_item.column;
			row_q   <= q_item.row;
			limit_q <= q_item.limit[CNT_W-1:0];
			count_q <= '0;
			x_q     <= '0;
			y_q     <= '0;
		end
		if (mul_en) begin
			x2_q <= xm * xm;
			y2_q <= ym * ym;
			xy_q <= xm * ym;
		end
		if (step_en) begin
			x_q     <= x_next;
			y_q     <= y_next;
			count_q <= count_q + CNT_W'(1);
		end
	end

	// Output register: hold a result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_res_q.stayed_bounded  <= (count_q == limit_q);
			out_res_q.iteration_count <= met_pkg::CNT_OUT_W'(count_q);
			out_res_q.row             <= row_q;
			out_res_q.column          <= col_q;
		end
	end

	assign q_ready   = q_pop;
	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

	`MET_ASSERT_NOW(a_count_in_limit, state_q == met_pkg::ENG_MUL || state_q == met_pkg::ENG_ACC, count_q <= limit_q, "iteration count above limit")
	`MET_ASSERT_NOW(a_acc_after_mul, state_q == met_pkg::ENG_ACC, $past(state_q) == met_pkg::ENG_MUL, "update cycle without multiply cycle")
	`MET_ASSERT_NOW(a_squares_pos, state_q == met_pkg::ENG_ACC, !x2_q[P_W-1] && !y2_q[P_W-1], "negative square in update cycle")

endmodule

FILE: rtl/core/mandelbrot_escape_time_unit.sv
// A pixel holds the iteration engine until its result enters the output register:
// every iteration passes the three multipliers (two squares, cross product) and
// then the update state, where the magnitude test can end it early.
// While a pixel iterates, four more requests fit in the front stages and queue.
// Reset clears all handshake state and loads the register defaults at once.
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_unit
// Escape-time engine for one pixel per request: maps column and row to c,
// iterates z = z^2 + c from zero and returns the iteration count.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_unit #(
	parameter int COUNT_BITS = met_pkg::COUNT_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// pixel requests
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [23:0]                  s_axis_tdata,  // [11:0] pixel_column, [23:12] pixel_row
	// results
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [47:0]                  m_axis_tdata,  // [11:0] out_column, [23:12] out_row,
	                                                    // [39:24] iteration_count,
	                                                    // [40] stayed_bounded, rest zero
	// configuration
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [met_pkg::ADDR_W-1:0]   paddr,
	input  logic [met_pkg::DATA_W-1:0]   pwdata,
	output logic [met_pkg::DATA_W-1:0]   prdata,
	output logic                         pready
);

	met_pkg::met_cfg_t               cfg_q;
	logic                            wr_en;
	logic [met_pkg::REG_IDX_W-1:0]   reg_idx;
	logic                            q_in_valid;
	logic                            q_in_ready;
	met_pkg::met_item_t              q_in_item;
	logic                            q_out_valid;
	logic                            q_out_ready;
	met_pkg::met_item_t              q_out_item;
	met_pkg::met_result_t            res;

	assign pready  = 1'b1;
	assign reg_idx = paddr[met_pkg::ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite && pready;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.x_start        <= met_pkg::X_START_RST;
			cfg_q.y_start        <= met_pkg::Y_START_RST;
			cfg_q.x_step         <= met_pkg::X_STEP_RST;
			cfg_q.y_step         <= met_pkg::Y_STEP_RST;
			cfg_q.max_iterations <= met_pkg::MAX_ITER_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				met_pkg::REG_X_START:  cfg_q.x_start        <= pwdata;
				met_pkg::REG_Y_START:  cfg_q.y_start        <= pwdata;
				met_pkg::REG_X_STEP:   cfg_q.x_step         <= pwdata[met_pkg::STEP_W-1:0];
				met_pkg::REG_Y_STEP:   cfg_q.y_step         <= pwdata[met_pkg::STEP_W-1:0];
				met_pkg::REG_MAX_ITER: cfg_q.max_iterations <= pwdata[met_pkg::CNT_OUT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Register reads
	always_comb begin
		unique case (reg_idx)
			met_pkg::REG_X_START:  prdata = cfg_q.x_start;
			met_pkg::REG_Y_START:  prdata = cfg_q.y_start;
			met_pkg::REG_X_STEP:   prdata = met_pkg::DATA_W'(cfg_q.x_step);
			met_pkg::REG_Y_STEP:   prdata = met_pkg::DATA_W'(cfg_q.y_step);
			met_pkg::REG_MAX_ITER: prdata = met_pkg::DATA_W'(cfg_q.max_iterations);
			default:               prdata = '0;
		endcase
	end

	met_front #(
		.COUNT_BITS (COUNT_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_column (s_axis_tdata[11:0]),
		.in_row    (s_axis_tdata[23:12]),
		.q_valid   (q_in_valid),
		.q_ready   (q_in_ready),
		.q_item    (q_in_item)
	);

	met_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (q_in_valid),
		.push_ready (q_in_ready),
		.push_item  (q_in_item),
		.pop_valid  (q_out_valid),
		.pop_ready  (q_out_ready),
		.pop_item   (q_out_item)
	);

	met_engine #(
		.COUNT_BITS (COUNT_BITS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_out_valid),
		.q_ready   (q_out_ready),
		.q_item    (q_out_item),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res)
	);

	assign m_axis_tdata = {7'd0, res};

endmodule
